// ----- rtl/bmhq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the binary min-heap queue
// Sizes, operation and status codes, the heap entry, and the structs that
// travel between the level cells and the top level.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  // Number of heap slots and field widths.
  localparam int unsigned DEPTH = 256;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned PAY_W = 16;
  localparam int unsigned ENT_W = KEY_W + PAY_W;

  // Positions are 1-based and must hold DEPTH itself.
  localparam int unsigned POS_W = $clog2(DEPTH + 1);
  // Tree levels 0 .. NLVL-1; level 0 is the root register.
  localparam int unsigned NLVL  = $clog2(DEPTH + 1);
  localparam int unsigned LVL_W = $clog2(NLVL);

  // Operation codes of a request.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PEEK   = 2'd2
  } func_e;

  // Status codes of a response.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Kind of walk a token performs through the level cells.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_LOAD  = 2'd2,
    ST_WALK  = 2'd3
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // Token handed from one level cell to the next. ppos is the position of
  // the parent node, which lives one level above the receiving cell.
  typedef struct packed {
    logic             valid;
    op_e              op;
    entry_t           carry;
    logic             shift;
    logic [POS_W-1:0] ppos;
    logic [LVL_W-1:0] dlvl;
  } tok_t;

  // Write of an entry into the level above (sift-down moves entries up).
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    entry_t           ent;
  } wb_t;

  // Read of the last entry before a sift-down.
  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] lvl;
    logic [POS_W-1:0] pos;
  } fetch_t;

  // Access to the pair memories of one level.
  typedef struct packed {
    logic             re;
    logic             we;
    logic             wside;
    logic [POS_W-1:0] row;
    entry_t           wdata;
  } mem_req_t;

  // Rows of sibling pairs needed at one level.
  function automatic int unsigned lvl_rows(int unsigned l);
    int unsigned top_pos;
    top_pos = (2 ** (l + 1)) - 1;
    if (top_pos > DEPTH) begin
      top_pos = DEPTH;
    end
    return ((top_pos - (2 ** l)) >> 1) + 1;
  endfunction

  // Index of the highest set bit.
  function automatic logic [LVL_W-1:0] msb_idx(logic [POS_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (v[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/bmhq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_if: request and response channels of the binary min-heap queue
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [bmhq_pkg::KEY_W-1:0] key;
  logic [bmhq_pkg::PAY_W-1:0] payload;

  modport source (output valid, output func, output key, output payload, input ready);
  modport sink   (input valid, input func, input key, input payload, output ready);
endinterface

interface bmhq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bmhq_pkg::KEY_W-1:0] min_key;
  logic [bmhq_pkg::PAY_W-1:0] min_payload;
  logic [1:0]                 status;
  logic [bmhq_pkg::POS_W-1:0] count;

  modport source (output valid, output min_key, output min_payload, output status,
                  output count, input ready);
  modport sink   (input valid, input min_key, input min_payload, input status,
                  input count, output ready);
endinterface

// ----- rtl/bmhq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram: single-port RAM with registered read data
// One access per cycle; read data holds until the next read.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bmhq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_cell: one level of the heap tree
// Takes the token from the level above, reads the sibling pair under the
// parent node, decides the move and passes the token to the level below.
// ----------------------------------------------------------------------------
module bmhq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bmhq_pkg::LVL_W-1:0] lvl_i,
  input  logic [bmhq_pkg::POS_W-1:0] count_i,
  input  bmhq_pkg::tok_t             tok_i,
  output bmhq_pkg::tok_t             tok_o,
  input  bmhq_pkg::wb_t              wb_i,
  output bmhq_pkg::wb_t              wb_o,
  input  bmhq_pkg::fetch_t           fetch_i,
  output bmhq_pkg::mem_req_t         mreq_o,
  input  bmhq_pkg::entry_t           rd_l_i,
  input  bmhq_pkg::entry_t           rd_r_i,
  output logic                       done_o
);

  bmhq_pkg::tok_t tok_q;
  logic           a_q;
  logic           b_q;

  logic [bmhq_pkg::POS_W-1:0] base;
  logic [bmhq_pkg::LVL_W-1:0] bidx;
  logic                       ins_bit;
  logic [bmhq_pkg::POS_W-1:0] prow;
  logic [bmhq_pkg::POS_W:0]   c_left;
  logic [bmhq_pkg::POS_W:0]   c_right;
  logic [bmhq_pkg::POS_W:0]   cnt_x;
  logic                       has_left;
  logic                       has_right;
  logic                       at_target;
  logic                       need_read;
  logic                       pick_r;
  bmhq_pkg::entry_t           node;
  bmhq_pkg::entry_t           child;
  logic [bmhq_pkg::POS_W-1:0] ch_pos;
  logic                       ch_leaf;

  // Phase A holds a fresh token; phase B sees the pair read for it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 1'b0;
      b_q <= 1'b0;
    end else begin
      a_q <= tok_i.valid;
      b_q <= a_q && need_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      tok_q <= tok_i;
    end
  end

  // Path and child addressing within this level.
  always_comb begin
    base      = bmhq_pkg::POS_W'(1) << (lvl_i - bmhq_pkg::LVL_W'(1));
    bidx      = tok_q.dlvl - lvl_i;
    ins_bit   = count_i[bidx];
    prow      = tok_q.ppos ^ base;
    c_left    = {tok_q.ppos, 1'b0};
    c_right   = {tok_q.ppos, 1'b1};
    cnt_x     = {1'b0, count_i};
    has_left  = c_left <= cnt_x;
    has_right = c_right <= cnt_x;
    at_target = tok_q.dlvl == lvl_i;
    need_read = (tok_q.op == bmhq_pkg::OP_INSERT) ? !at_target : has_left;
    node      = ins_bit ? rd_r_i : rd_l_i;
    pick_r    = has_right && (rd_r_i.key < rd_l_i.key);
    child     = pick_r ? rd_r_i : rd_l_i;
    ch_pos    = bmhq_pkg::POS_W'({tok_q.ppos, pick_r});
    ch_leaf   = {ch_pos, 1'b0} > cnt_x;
  end

  // Step decisions and memory access.
  always_comb begin
    mreq_o = '0;
    tok_o  = '0;
    wb_o   = '0;
    done_o = 1'b0;
    if (a_q) begin
      mreq_o.row = prow;
      if (tok_q.op == bmhq_pkg::OP_INSERT) begin
        if (at_target) begin
          // The new slot: drop what is carried there.
          mreq_o.we    = 1'b1;
          mreq_o.wside = ins_bit;
          mreq_o.wdata = tok_q.carry;
          done_o       = 1'b1;
        end else begin
          mreq_o.re = 1'b1;
        end
      end else begin
        if (has_left) begin
          mreq_o.re = 1'b1;
        end else begin
          wb_o   = '{valid: 1'b1, pos: tok_q.ppos, ent: tok_q.carry};
          done_o = 1'b1;
        end
      end
    end else if (b_q) begin
      mreq_o.row = prow;
      if (tok_q.op == bmhq_pkg::OP_INSERT) begin
        // Once the new key has displaced a node, every node below shifts down.
        tok_o       = tok_q;
        tok_o.ppos  = bmhq_pkg::POS_W'({tok_q.ppos, ins_bit});
        if (tok_q.shift || (tok_q.carry.key < node.key)) begin
          mreq_o.we    = 1'b1;
          mreq_o.wside = ins_bit;
          mreq_o.wdata = tok_q.carry;
          tok_o.carry  = node;
          tok_o.shift  = 1'b1;
        end
      end else begin
        if (child.key < tok_q.carry.key) begin
          // Smaller child moves up into the parent slot.
          wb_o = '{valid: 1'b1, pos: tok_q.ppos, ent: child};
          if (ch_leaf) begin
            mreq_o.we    = 1'b1;
            mreq_o.wside = pick_r;
            mreq_o.wdata = tok_q.carry;
            done_o       = 1'b1;
          end else begin
            tok_o      = tok_q;
            tok_o.ppos = ch_pos;
          end
        end else begin
          wb_o   = '{valid: 1'b1, pos: tok_q.ppos, ent: tok_q.carry};
          done_o = 1'b1;
        end
      end
    end else if (wb_i.valid) begin
      // Entry moved up from the level below.
      mreq_o.we    = 1'b1;
      mreq_o.row   = (wb_i.pos >> 1) ^ base;
      mreq_o.wside = wb_i.pos[0];
      mreq_o.wdata = wb_i.ent;
    end else if (fetch_i.valid && (fetch_i.lvl == lvl_i)) begin
      mreq_o.re  = 1'b1;
      mreq_o.row = (fetch_i.pos >> 1) ^ base;
    end
  end

endmodule

// ----- rtl/binary_min_heap_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue: key/payload priority queue on a binary min-heap
// The root sits in a register; every deeper tree level is a cell with a pair
// memory, and an insert or removal that reaches below the root sends one token down the cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries func (insert, remove minimum, peek minimum), key and payload.
//   rsp returns min_key, min_payload, status and the entry count after the
//   operation, one response per request transaction.
//   The response is registered and valid the cycle after the request is
//   accepted; it holds while the receiver stalls, and no new request is taken
//   until it has been taken or is leaving in the same cycle.
//   Peek, refused insert, insert into an empty heap and removal from an empty
//   or one-entry heap finish at acceptance, leaving the controller idle. An
//   insert walks the path down to the level of the new slot; a removal first
//   fetches the last entry (states ST_FETCH and ST_LOAD) and then walks down
//   from the root. No request is taken until the walk is done. Each level
//   cell first reads the sibling pair and then compares and writes.
//   Reset empties the heap at once; the memories are not cleared, since slots
//   above the count are never read.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
  input  logic clk_i,
  input  logic rst_ni,
  bmhq_req_if.sink   req,
  bmhq_rsp_if.source rsp
);

  bmhq_pkg::state_e           state_q, state_d;
  logic [bmhq_pkg::POS_W-1:0] count_q, count_d;
  bmhq_pkg::entry_t           root_q, root_d;
  logic [bmhq_pkg::POS_W-1:0] last_pos_q, last_pos_d;
  logic [bmhq_pkg::LVL_W-1:0] last_lvl_q, last_lvl_d;

  logic                       rsp_valid_q;
  logic [bmhq_pkg::KEY_W-1:0] rsp_key_q;
  logic [bmhq_pkg::PAY_W-1:0] rsp_pay_q;
  bmhq_pkg::status_e          rsp_status_q;
  logic [bmhq_pkg::POS_W-1:0] rsp_count_q;

  logic                       accept;
  bmhq_pkg::entry_t           new_ent;
  bmhq_pkg::entry_t           last_ent;
  logic [bmhq_pkg::KEY_W-1:0] o_key;
  logic [bmhq_pkg::PAY_W-1:0] o_pay;
  bmhq_pkg::status_e          o_status;
  bmhq_pkg::tok_t             tok1;
  bmhq_pkg::fetch_t           fetch;

  bmhq_pkg::tok_t     tok   [1:bmhq_pkg::NLVL];
  bmhq_pkg::wb_t      wb    [1:bmhq_pkg::NLVL];
  bmhq_pkg::mem_req_t mreq  [1:bmhq_pkg::NLVL-1];
  bmhq_pkg::entry_t   rd_l  [1:bmhq_pkg::NLVL-1];
  bmhq_pkg::entry_t   rd_r  [1:bmhq_pkg::NLVL-1];
  logic [bmhq_pkg::NLVL-1:1] done_w;

  assign req.ready = (state_q == bmhq_pkg::ST_IDLE) && (!rsp_valid_q || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign new_ent   = '{key: req.key, payload: req.payload};

  assign fetch = '{valid: (state_q == bmhq_pkg::ST_FETCH), lvl: last_lvl_q, pos: last_pos_q};
  assign tok[1] = tok1;
  assign wb[bmhq_pkg::NLVL] = '0;

  // Level cells with their left and right sibling memories.
  for (genvar l = 1; l < bmhq_pkg::NLVL; l++) begin : g_lvl
    localparam int unsigned ROWS = bmhq_pkg::lvl_rows(l);
    localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    bmhq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .lvl_i   (bmhq_pkg::LVL_W'(l)),
      .count_i (count_q),
      .tok_i   (tok[l]),
      .tok_o   (tok[l+1]),
      .wb_i    (wb[l+1]),
      .wb_o    (wb[l]),
      .fetch_i (fetch),
      .mreq_o  (mreq[l]),
      .rd_l_i  (rd_l[l]),
      .rd_r_i  (rd_r[l]),
      .done_o  (done_w[l])
    );

    bmhq_ram #(
      .WIDTH (bmhq_pkg::ENT_W),
      .DEPTH (ROWS)
    ) u_ram_l (
      .clk_i   (clk_i),
      .we_i    (mreq[l].we && !mreq[l].wside),
      .re_i    (mreq[l].re),
      .addr_i  (RW'(mreq[l].row)),
      .wdata_i (mreq[l].wdata),
      .rdata_o (rd_l[l])
    );

    bmhq_ram #(
      .WIDTH (bmhq_pkg::ENT_W),
      .DEPTH (ROWS)
    ) u_ram_r (
      .clk_i   (clk_i),
      .we_i    (mreq[l].we && mreq[l].wside),
      .re_i    (mreq[l].re),
      .addr_i  (RW'(mreq[l].row)),
      .wdata_i (mreq[l].wdata),
      .rdata_o (rd_r[l])
    );
  end

  // Controller: answers at acceptance, then launches the walk.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    root_d     = root_q;
    last_pos_d = last_pos_q;
    last_lvl_d = last_lvl_q;
    tok1       = '0;
    o_key      = '0;
    o_pay      = '0;
    o_status   = bmhq_pkg::STAT_OK;
    last_ent   = last_pos_q[0] ? rd_r[last_lvl_q] : rd_l[last_lvl_q];
    case (state_q)
      bmhq_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.func)
            bmhq_pkg::FUNC_INSERT: begin
              if (count_q == bmhq_pkg::POS_W'(bmhq_pkg::DEPTH)) begin
                o_status = bmhq_pkg::STAT_FULL;
              end else begin
                count_d = count_q + bmhq_pkg::POS_W'(1);
                if (count_q == '0) begin
                  root_d = new_ent;
                end else begin
                  tok1.valid = 1'b1;
                  tok1.op    = bmhq_pkg::OP_INSERT;
                  tok1.ppos  = bmhq_pkg::POS_W'(1);
                  tok1.dlvl  = bmhq_pkg::msb_idx(count_d);
                  if (new_ent.key < root_q.key) begin
                    root_d     = new_ent;
                    tok1.carry = root_q;
                    tok1.shift = 1'b1;
                  end else begin
                    tok1.carry = new_ent;
                    tok1.shift = 1'b0;
                  end
                  state_d = bmhq_pkg::ST_WALK;
                end
              end
            end
            bmhq_pkg::FUNC_REMOVE: begin
              if (count_q == '0) begin
                o_status = bmhq_pkg::STAT_EMPTY;
              end else begin
                o_key   = root_q.key;
                o_pay   = root_q.payload;
                count_d = count_q - bmhq_pkg::POS_W'(1);
                if (count_q != bmhq_pkg::POS_W'(1)) begin
                  last_pos_d = count_q;
                  last_lvl_d = bmhq_pkg::msb_idx(count_q);
                  state_d    = bmhq_pkg::ST_FETCH;
                end
              end
            end
            bmhq_pkg::FUNC_PEEK: begin
              if (count_q == '0) begin
                o_status = bmhq_pkg::STAT_EMPTY;
              end else begin
                o_key = root_q.key;
                o_pay = root_q.payload;
              end
            end
            default: begin
              o_status = bmhq_pkg::STAT_OK;
            end
          endcase
        end
      end
      bmhq_pkg::ST_FETCH: begin
        state_d = bmhq_pkg::ST_LOAD;
      end
      bmhq_pkg::ST_LOAD: begin
        // The last entry goes to the root and sinks from there.
        tok1.valid = 1'b1;
        tok1.op    = bmhq_pkg::OP_REMOVE;
        tok1.carry = last_ent;
        tok1.shift = 1'b0;
        tok1.ppos  = bmhq_pkg::POS_W'(1);
        tok1.dlvl  = '0;
        state_d    = bmhq_pkg::ST_WALK;
      end
      bmhq_pkg::ST_WALK: begin
        if (wb[1].valid) begin
          root_d = wb[1].ent;
        end
        if (|done_w) begin
          state_d = bmhq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmhq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q     <= root_d;
    last_pos_q <= last_pos_d;
    last_lvl_q <= last_lvl_d;
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_key_q    <= o_key;
      rsp_pay_q    <= o_pay;
      rsp_status_q <= o_status;
      rsp_count_q  <= count_d;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.min_key     = rsp_key_q;
  assign rsp.min_payload = rsp_pay_q;
  assign rsp.status      = rsp_status_q;
  assign rsp.count       = rsp_count_q;

endmodule

// ----- rtl/bmhq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_checker: port-level checks of the binary min-heap queue
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [bmhq_pkg::KEY_W-1:0] rsp_key_i,
  input logic [bmhq_pkg::PAY_W-1:0] rsp_payload_i,
  input logic [1:0]                 rsp_status_i,
  input logic [bmhq_pkg::POS_W-1:0] rsp_count_i
);

  // Every accepted request has its response waiting in the next cycle.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> rsp_valid_i)
    else $error("response missing after request transaction");

  // A pending response is never overwritten by a new request.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |-> (!rsp_valid_i || rsp_ready_i))
    else $error("request accepted while response stalled");

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_key_i) && $stable(rsp_payload_i) &&
       $stable(rsp_status_i) && $stable(rsp_count_i)))
    else $error("stalled response changed");

  // An empty status reports an empty heap and no entry.
  a_empty_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == bmhq_pkg::STAT_EMPTY)) |->
      ((rsp_count_i == '0) && (rsp_key_i == '0) && (rsp_payload_i == '0)))
    else $error("empty status with entries or data");

  // A refused insert only happens at full occupancy.
  a_full_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == bmhq_pkg::STAT_FULL)) |->
      (rsp_count_i == bmhq_pkg::POS_W'(bmhq_pkg::DEPTH)))
    else $error("full status below capacity");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req.valid),
  .req_ready_i   (req.ready),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .rsp_key_i     (rsp.min_key),
  .rsp_payload_i (rsp.min_payload),
  .rsp_status_i  (rsp.status),
  .rsp_count_i   (rsp.count)
);

// ----- bench/binary_min_heap_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb: self-checking bench for the min-heap queue
// Drives insert, remove-minimum and peek requests with random gaps, stalls
// the response channel at random, and checks every response against a
// behavioral heap kept in a scoreboard. Directed requests cover empty and
// one-entry heaps, extreme keys and payloads, equal keys and the unused
// operation code. Random phases fill the heap past full, drain it past
// empty, and churn it with keys from a narrow range.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;
  import bmhq_pkg::*;

  // The operation code that has no function; the queue must just report count.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] min_key;
    logic [PAY_W-1:0] min_payload;
    logic [1:0]       status;
    logic [POS_W-1:0] count;
  } heap_rsp_t;

  // Behavioral heap and the responses it predicts, oldest first.
  class HeapScoreboard;
    logic [KEY_W-1:0] slot_key [1:DEPTH];
    logic [PAY_W-1:0] slot_pay [1:DEPTH];
    int unsigned      fill;
    heap_rsp_t        awaited [$];
    int unsigned      failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    // Applies one accepted request to the heap and queues its response.
    function void note_request(logic [1:0] func, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] payload);
      heap_rsp_t        rsp_exp;
      int unsigned      pos;
      int unsigned      child;
      logic [KEY_W-1:0] k;
      logic [PAY_W-1:0] p;
      bit               sinking;
      rsp_exp        = '0;
      rsp_exp.status = STAT_OK;
      if (func == FUNC_INSERT) begin
        if (fill >= DEPTH) begin
          rsp_exp.status = STAT_FULL;
        end else begin
          // New slot at the end; climb while strictly smaller than the parent.
          fill++;
          pos = fill;
          while (pos > 1 && key < slot_key[pos / 2]) begin
            slot_key[pos] = slot_key[pos / 2];
            slot_pay[pos] = slot_pay[pos / 2];
            pos = pos / 2;
          end
          slot_key[pos] = key;
          slot_pay[pos] = payload;
        end
      end else if (func == FUNC_REMOVE || func == FUNC_PEEK) begin
        if (fill == 0) begin
          rsp_exp.status = STAT_EMPTY;
        end else begin
          rsp_exp.min_key     = slot_key[1];
          rsp_exp.min_payload = slot_pay[1];
          if (func == FUNC_REMOVE) begin
            // Last entry goes to the root and sinks toward the smaller child;
            // the right child wins only when strictly smaller than the left.
            k = slot_key[fill];
            p = slot_pay[fill];
            fill--;
            if (fill > 0) begin
              pos     = 1;
              child   = 2;
              sinking = 1'b1;
              while (sinking && child <= fill) begin
                if (child != fill && slot_key[child + 1] < slot_key[child]) begin
                  child++;
                end
                if (slot_key[child] < k) begin
                  slot_key[pos] = slot_key[child];
                  slot_pay[pos] = slot_pay[child];
                  pos   = child;
                  child = 2 * pos;
                end else begin
                  sinking = 1'b0;
                end
              end
              slot_key[pos] = k;
              slot_pay[pos] = p;
            end
          end
        end
      end
      rsp_exp.count = POS_W'(fill);
      awaited.push_back(rsp_exp);
    endfunction

    function void report_field(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      failures++;
    endfunction

    // Compares one accepted response with the oldest prediction.
    function void check_response(heap_rsp_t got);
      heap_rsp_t want;
      if (awaited.size() == 0) begin
        $display("%0t: response with nothing outstanding, got %p", $time, got);
        failures++;
      end else begin
        want = awaited.pop_front();
        if (got.min_key !== want.min_key)
          report_field("min_key", want.min_key, got.min_key);
        if (got.min_payload !== want.min_payload)
          report_field("min_payload", want.min_payload, got.min_payload);
        if (got.status !== want.status)
          report_field("status", want.status, got.status);
        if (got.count !== want.count)
          report_field("count", want.count, got.count);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   quiet;

  bmhq_req_if req_ch ();
  bmhq_rsp_if rsp_ch ();

  HeapScoreboard board;

  binary_min_heap_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long; none in quiet phases.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Response side: runs of ready broken by random stalls.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned stall;
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Every accepted response transaction is checked.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      board.check_response('{rsp_ch.min_key, rsp_ch.min_payload, rsp_ch.status,
                             rsp_ch.count});
    end
  end

  // Presents one request after a random gap and waits until it is accepted.
  task automatic send_request(logic [1:0] func, logic [KEY_W-1:0] key,
                              logic [PAY_W-1:0] payload);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= func;
    req_ch.key     <= key;
    req_ch.payload <= payload;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    board.note_request(func, key, payload);
  endtask

  // Random requests; the percentages steer the heap toward full or empty.
  task automatic run_phase(int unsigned items, int unsigned ins_pct,
                           int unsigned rem_pct, bit narrow);
    int unsigned      r;
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < 2)                          func = FUNC_UNUSED;
      else if (r < 2 + ins_pct)           func = FUNC_INSERT;
      else if (r < 2 + ins_pct + rem_pct) func = FUNC_REMOVE;
      else                                func = FUNC_PEEK;
      key = narrow ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom_range(0, 65535));
      send_request(func, key, PAY_W'($urandom_range(0, 65535)));
    end
  endtask

  // Main sequence: reset, directed requests, random phases, drain, verdict.
  initial begin
    board = new();
    quiet = 1'b0;
    rst_ni         <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.func    <= FUNC_INSERT;
    req_ch.key     <= '0;
    req_ch.payload <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty heap: peek, removal and the unused code.
    send_request(FUNC_PEEK,   16'h0000, 16'h0000);
    send_request(FUNC_REMOVE, 16'h0000, 16'h0000);
    send_request(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
    // Single entry taken out again.
    send_request(FUNC_INSERT, 16'h1234, 16'h5678);
    send_request(FUNC_REMOVE, 16'h0000, 16'h0000);
    // Extreme keys and payloads, then equal keys in several positions.
    send_request(FUNC_INSERT, 16'hFFFF, 16'h0000);
    send_request(FUNC_INSERT, 16'h0000, 16'hFFFF);
    send_request(FUNC_PEEK,   16'h0000, 16'h0000);
    send_request(FUNC_INSERT, 16'h0005, 16'h0001);
    send_request(FUNC_INSERT, 16'h0005, 16'h0002);
    send_request(FUNC_INSERT, 16'h0005, 16'h0003);
    send_request(FUNC_INSERT, 16'h0000, 16'hAAAA);
    send_request(FUNC_INSERT, 16'h0005, 16'h0004);
    send_request(FUNC_UNUSED, 16'h5555, 16'h5555);
    repeat (7) send_request(FUNC_REMOVE, 16'h0000, 16'h0000);
    send_request(FUNC_REMOVE, 16'h0000, 16'h0000);
    send_request(FUNC_PEEK,   16'h0000, 16'h0000);

    // Fill past full, drain past empty, then churn with many equal keys.
    run_phase(330, 93, 3, 1'b0);
    run_phase(320, 5, 88, 1'b0);
    quiet = 1'b1;
    run_phase(100, 45, 40, 1'b1);
    quiet = 1'b0;
    run_phase(100, 45, 40, 1'b1);
    req_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASS binary_min_heap_queue");
    end else begin
      $display("FAIL binary_min_heap_queue");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL binary_min_heap_queue");
    $finish;
  end

endmodule
